// ===== design/rau_pkg.sv =====
package rau_pkg;

  localparam int FIELD_W = 32;
  localparam int DEN_W   = 31;

  localparam logic [2:0] CMD_ADD  = 3'd0;
  localparam logic [2:0] CMD_SUB  = 3'd1;
  localparam logic [2:0] CMD_MUL  = 3'd2;
  localparam logic [2:0] CMD_DIV  = 3'd3;
  localparam logic [2:0] CMD_NEG  = 3'd4;
  localparam logic [2:0] CMD_NORM = 3'd5;
  localparam logic [2:0] CMD_CMP  = 3'd6;
  localparam logic [2:0] CMD_NOP  = 3'd7;

  localparam logic signed [1:0] ORD_LT = -2'sd1;
  localparam logic signed [1:0] ORD_EQ = 2'sd0;
  localparam logic signed [1:0] ORD_GT = 2'sd1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_ZDEN = 2'd2;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic borrow;
    logic zero;
  } alu_flags_t;

endpackage

// ===== design/rau_mul.sv =====
module rau_mul #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                       clk,
  input  logic [VALUE_WIDTH-1:0]     x,
  input  logic [VALUE_WIDTH-1:0]     y,
  output logic [2*VALUE_WIDTH-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= x * y;
  end

endmodule

// ===== design/rau_alu.sv =====
module rau_alu #(
  parameter int AW = 65
) (
  input  rau_pkg::alu_op_t   op,
  input  logic [AW-1:0]      a,
  input  logic [AW-1:0]      b,
  output logic [AW-1:0]      res,
  output rau_pkg::alu_flags_t flags
);

  import rau_pkg::*;

  logic [AW:0] wide;

  always_comb begin
    if (op == ALU_ADD) begin
      wide = {1'b0, a} + {1'b0, b};
    end else begin
      wide = {1'b0, a} - {1'b0, b};
    end
    res          = wide[AW-1:0];
    flags.borrow = (op == ALU_SUB) && wide[AW];
    flags.zero   = (wide[AW-1:0] == '0);
  end

endmodule

// ===== design/rational_arithmetic_unit.sv =====
// Rational arithmetic unit. A transaction is taken when start is high and busy is low; busy
// then stays high until the cycle in which the result is presented, when the next transaction
// may already be taken. The result appears on res_num, res_den, order and status for exactly
// one cycle with done high, and the receiver cannot stall it.
// Cross products come from one registered multiplier, three products in turn. All later work
// (signed add, compare, binary gcd and two exact restoring divides by the gcd) runs on one
// shared adder/subtractor of 2*VALUE_WIDTH+1 bits, one step per cycle. A zero denominator
// or the unused command goes straight to the result. For arithmetic commands the run time
// is set by the gcd loop and the 2*VALUE_WIDTH steps of each of the two divides; a zero
// result finishes early.
module rational_arithmetic_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [2:0]                             cmd,
  input  logic signed [rau_pkg::FIELD_W-1:0]     a_num,
  input  logic signed [rau_pkg::FIELD_W-1:0]     a_den,
  input  logic signed [rau_pkg::FIELD_W-1:0]     b_num,
  input  logic signed [rau_pkg::FIELD_W-1:0]     b_den,
  output logic                                   done,
  output logic signed [rau_pkg::FIELD_W-1:0]     res_num,
  output logic [rau_pkg::DEN_W-1:0]              res_den,
  output logic signed [1:0]                      order,
  output logic [1:0]                             status
);

  import rau_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int DW = 2 * VALUE_WIDTH;
  localparam int AW = DW + 1;
  localparam int CW = $clog2(DW);
  localparam logic [DW-1:0] LIM    = DW'(1) << (VALUE_WIDTH - 1);
  localparam logic [DW-1:0] LIM_M1 = LIM - DW'(1);
  localparam logic [CW-1:0] CNT_LAST = CW'(DW - 1);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_MUL1 = 11'b00000000010,
    S_MUL2 = 11'b00000000100,
    S_MUL3 = 11'b00000001000,
    S_MUL4 = 11'b00000010000,
    S_COMB = 11'b00000100000,
    S_TWO  = 11'b00001000000,
    S_GCD  = 11'b00010000000,
    S_DIVN = 11'b00100000000,
    S_DIVD = 11'b01000000000,
    S_FIN  = 11'b10000000000
  } state_t;

  typedef enum logic [1:0] {
    FIN_VALUE,
    FIN_CMP,
    FIN_ZDEN,
    FIN_NOP
  } fin_t;

  state_t        state;
  fin_t          fin;
  logic [2:0]    op;
  logic [W-1:0]  an, ad, bn, bd;
  logic          xs, ys, rneg;
  logic [DW-1:0] x, y, num, den, rem;
  logic [CW-1:0] cnt;
  logic signed [1:0] ord;

  logic [W-1:0]  an_raw, ad_raw, bn_raw, bd_raw;
  logic [W-1:0]  an_mag, ad_mag, bn_mag, bd_mag;
  logic          a_neg, b_neg, zden, two;

  logic [W-1:0]  mx, my;
  logic [DW-1:0] p;

  alu_op_t       alu_op;
  logic [AW-1:0] alu_a, alu_b, alu_res;
  alu_flags_t    flags;

  logic          sx, sy, ovf;
  logic [AW-1:0] shifted;
  logic          dvd_msb;
  logic [FIELD_W-1:0] num_out;

  assign an_raw = a_num[W-1:0];
  assign ad_raw = a_den[W-1:0];
  assign bn_raw = b_num[W-1:0];
  assign bd_raw = b_den[W-1:0];
  assign an_mag = an_raw[W-1] ? (~an_raw + W'(1)) : an_raw;
  assign ad_mag = ad_raw[W-1] ? (~ad_raw + W'(1)) : ad_raw;
  assign bn_mag = bn_raw[W-1] ? (~bn_raw + W'(1)) : bn_raw;
  assign bd_mag = bd_raw[W-1] ? (~bd_raw + W'(1)) : bd_raw;
  assign a_neg  = an_raw[W-1] ^ ad_raw[W-1];
  assign b_neg  = bn_raw[W-1] ^ bd_raw[W-1];
  assign two    = (cmd == CMD_ADD) || (cmd == CMD_SUB) || (cmd == CMD_MUL) ||
                  (cmd == CMD_DIV) || (cmd == CMD_CMP);
  assign zden   = (ad_raw == '0) || (two && (bd_raw == '0)) ||
                  ((cmd == CMD_DIV) && (bn_raw == '0));

  assign busy = (state != S_IDLE);

  always_comb begin
    mx = an;
    my = bd;
    case (state)
      S_MUL1: begin
        mx = an;
        my = (op == CMD_MUL) ? bn : bd;
      end
      S_MUL2: begin
        mx = bn;
        my = ad;
      end
      S_MUL3: begin
        mx = ad;
        my = (op == CMD_DIV) ? bn : bd;
      end
      default: begin
        mx = an;
        my = bd;
      end
    endcase
  end

  rau_mul #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_mul (
    .clk(clk),
    .x  (mx),
    .y  (my),
    .p  (p)
  );

  assign dvd_msb = (state == S_DIVD) ? den[DW-1] : num[DW-1];
  assign shifted = {rem, dvd_msb};

  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = {1'b0, x};
    alu_b  = {1'b0, y};
    case (state)
      S_COMB: begin
        alu_op = ((op == CMD_ADD || op == CMD_SUB) && (xs == ys)) ? ALU_ADD : ALU_SUB;
      end
      S_DIVN, S_DIVD: begin
        alu_a = shifted;
      end
      default: begin
        alu_op = ALU_SUB;
      end
    endcase
  end

  rau_alu #(
    .AW(AW)
  ) u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .res  (alu_res),
    .flags(flags)
  );

  assign sx  = xs && (x != '0);
  assign sy  = ys && (y != '0);
  assign ovf = (den > LIM_M1) || (num > (rneg ? LIM : LIM_M1));
  assign num_out = FIELD_W'(num);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op  <= cmd;
            an  <= an_mag;
            ad  <= ad_mag;
            bn  <= bn_mag;
            bd  <= bd_mag;
            xs  <= a_neg;
            ys  <= (cmd == CMD_SUB) ? ~b_neg : b_neg;
            fin <= FIN_VALUE;
            if (cmd == CMD_NOP) begin
              fin   <= FIN_NOP;
              state <= S_FIN;
            end else if (zden) begin
              fin   <= FIN_ZDEN;
              state <= S_FIN;
            end else if (cmd == CMD_NEG || cmd == CMD_NORM) begin
              num   <= {{W{1'b0}}, an_mag};
              den   <= {{W{1'b0}}, ad_mag};
              rneg  <= (cmd == CMD_NEG) ? ~a_neg : a_neg;
              state <= S_TWO;
            end else begin
              state <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          state <= S_MUL2;
        end
        S_MUL2: begin
          x     <= p;
          state <= S_MUL3;
        end
        S_MUL3: begin
          y     <= p;
          state <= S_MUL4;
        end
        S_MUL4: begin
          den <= p;
          if (op == CMD_MUL || op == CMD_DIV) begin
            num   <= x;
            rneg  <= xs ^ ys;
            state <= S_TWO;
          end else begin
            state <= S_COMB;
          end
        end
        S_COMB: begin
          if (op == CMD_CMP) begin
            if (sx != sy) begin
              ord <= sx ? ORD_LT : ORD_GT;
            end else if (flags.zero) begin
              ord <= ORD_EQ;
            end else if (!sx) begin
              ord <= flags.borrow ? ORD_LT : ORD_GT;
            end else begin
              ord <= flags.borrow ? ORD_GT : ORD_LT;
            end
            fin   <= FIN_CMP;
            state <= S_FIN;
          end else if (flags.borrow) begin
            x  <= y;
            y  <= x;
            xs <= ys;
            ys <= xs;
          end else begin
            num   <= alu_res[DW-1:0];
            rneg  <= xs;
            state <= S_TWO;
          end
        end
        S_TWO: begin
          if (num == '0) begin
            den   <= DW'(1);
            rneg  <= 1'b0;
            state <= S_FIN;
          end else if (!num[0] && !den[0]) begin
            num <= num >> 1;
            den <= den >> 1;
          end else begin
            x     <= num;
            y     <= den;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          if (flags.zero) begin
            rem   <= '0;
            cnt   <= '0;
            state <= S_DIVN;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (!flags.borrow) begin
            x <= alu_res[DW:1];
          end else begin
            x <= y;
            y <= x;
          end
        end
        S_DIVN: begin
          num <= {num[DW-2:0], ~flags.borrow};
          rem <= flags.borrow ? shifted[DW-1:0] : alu_res[DW-1:0];
          cnt <= cnt + CW'(1);
          if (cnt == CNT_LAST) begin
            rem   <= '0;
            cnt   <= '0;
            state <= S_DIVD;
          end
        end
        S_DIVD: begin
          den <= {den[DW-2:0], ~flags.borrow};
          rem <= flags.borrow ? shifted[DW-1:0] : alu_res[DW-1:0];
          cnt <= cnt + CW'(1);
          if (cnt == CNT_LAST) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          done    <= 1'b1;
          res_num <= '0;
          res_den <= DEN_W'(1);
          order   <= ORD_EQ;
          status  <= ST_OK;
          case (fin)
            FIN_VALUE: begin
              if (ovf) begin
                status <= ST_OVF;
              end else begin
                res_num <= rneg ? (~num_out + FIELD_W'(1)) : num_out;
                res_den <= DEN_W'(den);
              end
            end
            FIN_CMP: begin
              order <= ord;
            end
            FIN_ZDEN: begin
              status <= ST_ZDEN;
            end
            default: begin
              status <= ST_OK;
            end
          endcase
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
